// ----- hw/rtl/exact_byte_pattern_matcher_defines.svh -----
// Assertion macros for the exact byte pattern matcher.
`ifndef EXACT_BYTE_PATTERN_MATCHER_DEFINES_SVH
`define EXACT_BYTE_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EBPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("exact_byte_pattern_matcher: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EBPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("exact_byte_pattern_matcher: check failed");

`endif

// ----- hw/rtl/ebpm_pkg.sv -----
// Shared constants and types for the exact byte pattern matcher.
package ebpm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int PIDX_W      = $clog2(MAX_PATTERN);
	localparam int LEN_W       = PIDX_W + 1;
	localparam int OFFSET_BITS = 32;
	localparam int MATCH_W     = 32;
	localparam int BYTE_W      = 8;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TEXT = 1'b1;

	typedef struct packed {
		logic              shift_en;
		logic              load_en;
		logic              rot_en;
		logic              cmp_en;
		logic [BYTE_W-1:0] data;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/ebpm_cell.sv -----
// One cell of the matcher chain: a text byte, a pattern byte and their compare.
module ebpm_cell (
	input  logic                       clk,
	input  ebpm_pkg::cell_ctrl_t       ctrl,
	input  logic                       wr_sel,
	input  logic                       active,
	input  logic [ebpm_pkg::BYTE_W-1:0] text_in,
	input  logic [ebpm_pkg::BYTE_W-1:0] pat_in,
	output logic [ebpm_pkg::BYTE_W-1:0] text_out,
	output logic [ebpm_pkg::BYTE_W-1:0] pat_out,
	output logic                       eq
);
	import ebpm_pkg::*;

	logic [BYTE_W-1:0] text_q;
	logic [BYTE_W-1:0] pat_q;
	logic              eq_s2;

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			text_q <= text_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rot_en) begin
			pat_q <= pat_in;
		end else if (ctrl.load_en && wr_sel) begin
			pat_q <= ctrl.data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			eq_s2 <= !active || (text_q == pat_q);
		end
	end

	assign text_out = text_q;
	assign pat_out  = pat_q;
	assign eq       = eq_s2;

endmodule

// ----- hw/rtl/exact_byte_pattern_matcher.sv -----
// Exact byte pattern matcher: a row of compare cells fed by a byte stream.
//
// Items come in on item_valid/item_stall. With func low an item writes
// pattern byte data_byte at pattern_index; with func high it is a text
// byte of the current region, and last_byte closes the region, so the
// next text byte has offset zero. The user must write the pattern length
// via cfg_write_en/cfg_write_data only while the block is idle (not enforced).
// A text byte that completes an occurrence of the pattern gives one result
// on result_valid/result_stall: the start offset of the occurrence and the
// offset saturation flag. A result passes through the first stage, the
// compare stage and the output register. One item is taken per cycle; input
// stalls only while realigning or when a result waits in the output register,
// a second result is behind it and a text byte sits in the first stage.
// After a change of pattern length the pattern cells rotate by one
// position per cycle until they line up with the new length; item_stall
// is high while they rotate.
// Reset clears the region offset, the saturation flag and all valid flags
// and sets the pattern length to one; pattern bytes must be loaded again.
`include "exact_byte_pattern_matcher_defines.svh"

module exact_byte_pattern_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            func,
	input  logic [ebpm_pkg::PIDX_W-1:0]     pattern_index,
	input  logic [ebpm_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            last_byte,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [ebpm_pkg::MATCH_W-1:0]    match_offset,
	output logic                            offset_saturated,
	input  logic                            cfg_write_en,
	input  logic [ebpm_pkg::LEN_W-1:0]      cfg_write_data
);
	import ebpm_pkg::*;

	logic [LEN_W-1:0]       len_q;
	logic [PIDX_W-1:0]      align_q;
	logic [PIDX_W-1:0]      len_m1;
	logic                   aligned;

	logic [OFFSET_BITS-1:0] region_q;
	logic                   sat_q;
	logic                   pos_max;
	logic                   sat_new;
	logic                   win_ok;

	logic                   v1_q;
	logic [OFFSET_BITS-1:0] off_s1;
	logic                   sat_s1;
	logic                   v2_q;
	logic [OFFSET_BITS-1:0] off_s2;
	logic                   sat_s2;
	logic                   result_valid_q;
	logic [MATCH_W-1:0]     match_offset_q;
	logic                   offset_saturated_q;

	logic                   accept;
	logic                   text_acc;
	logic                   load_acc;
	logic                   hit2;
	logic                   o_free;
	logic                   s2_free;
	logic                   s1_free;
	logic [PIDX_W-1:0]      wr_pos;

	cell_ctrl_t             ctrl;
	logic [MAX_PATTERN-1:0] wr_sel;
	logic [MAX_PATTERN-1:0] active;
	logic [MAX_PATTERN-1:0] eq_vec;
	logic [BYTE_W-1:0]      text_chain [MAX_PATTERN];
	logic [BYTE_W-1:0]      pat_chain  [MAX_PATTERN];

	always_comb begin
		if (len_q == '0) begin
			len_m1 = '0;
		end else if (len_q > LEN_W'(MAX_PATTERN)) begin
			len_m1 = PIDX_W'(MAX_PATTERN - 1);
		end else begin
			len_m1 = PIDX_W'(len_q - LEN_W'(1));
		end
	end

	assign aligned = (align_q == len_m1);

	assign o_free  = !result_valid_q || !result_stall;
	assign hit2    = v2_q && (&eq_vec);
	assign s2_free = !hit2 || o_free;
	assign s1_free = !v1_q || s2_free;

	assign item_stall = !(s1_free && aligned);
	assign accept     = item_valid && !item_stall;
	assign text_acc   = accept && (func == FUNC_TEXT);
	assign load_acc   = accept && (func == FUNC_LOAD)
		&& ({1'b0, pattern_index} < LEN_W'(MAX_PATTERN));

	assign pos_max = (region_q == '1);
	assign sat_new = sat_q || pos_max;
	assign win_ok  = (region_q >= OFFSET_BITS'(len_m1));
	assign wr_pos  = align_q - pattern_index;

	always_comb begin
		ctrl.shift_en = text_acc;
		ctrl.load_en  = load_acc;
		ctrl.rot_en   = !aligned;
		ctrl.cmp_en   = v1_q && s2_free;
		ctrl.data     = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(1);
			align_q <= '0;
		end else begin
			if (cfg_write_en) begin
				len_q <= cfg_write_data;
			end
			if (!aligned) begin
				align_q <= align_q + PIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
			sat_q    <= 1'b0;
		end else if (text_acc) begin
			if (last_byte) begin
				region_q <= '0;
				sat_q    <= 1'b0;
			end else begin
				sat_q <= sat_new;
				if (!pos_max) begin
					region_q <= region_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q           <= 1'b0;
			v2_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v1_q <= text_acc && win_ok;
			end
			if (s2_free) begin
				v2_q <= v1_q;
			end
			if (o_free) begin
				result_valid_q <= hit2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc) begin
			off_s1 <= region_q - OFFSET_BITS'(len_m1);
			sat_s1 <= sat_new;
		end
		if (s2_free) begin
			off_s2 <= off_s1;
			sat_s2 <= sat_s1;
		end
		if (o_free && hit2) begin
			match_offset_q     <= MATCH_W'(off_s2);
			offset_saturated_q <= sat_s2;
		end
	end

	assign result_valid     = result_valid_q;
	assign match_offset     = match_offset_q;
	assign offset_saturated = offset_saturated_q;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		assign wr_sel[k] = (wr_pos == PIDX_W'(k));
		assign active[k] = (PIDX_W'(k) <= len_m1);

		ebpm_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_sel   (wr_sel[k]),
			.active   (active[k]),
			.text_in  ((k == 0) ? data_byte : text_chain[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
			.pat_in   (pat_chain[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
			.text_out (text_chain[k]),
			.pat_out  (pat_chain[k]),
			.eq       (eq_vec[k])
		);
	end

	`EBPM_ASSERT_NOW(a_no_accept_misaligned, item_valid && !item_stall, align_q == len_m1)
	`EBPM_ASSERT_NOW(a_sat_pins_offset, sat_q, region_q == '1)
	`EBPM_ASSERT_NEXT(a_region_closes, text_acc && last_byte, region_q == '0 && !sat_q)
	`EBPM_ASSERT_NOW(a_hit_needs_room, v1_q && hit2 && result_valid_q && result_stall, item_stall)

endmodule

// ----- bench/tb_exact_byte_pattern_matcher.sv -----
// Self-checking testbench for exact_byte_pattern_matcher: directed table, then random phases.
module tb_exact_byte_pattern_matcher;
	timeunit 1ns;
	timeprecision 1ps;
	import ebpm_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int SETTLE     = 12;
	localparam int PHASES     = 16;
	localparam int PHASE_SIZE = 125;
	localparam int HOLD_LEN   = 400;

	typedef struct packed {
		logic [MATCH_W-1:0] offset;
		logic               saturated;
	} match_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               func;
		logic [PIDX_W-1:0]  index;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic               typed;
		logic               hit;
		logic [MATCH_W-1:0] offset;
	} row_t;

	localparam int N_DIRECTED = 23;

	row_t directed [N_DIRECTED] = '{
		'{ROW_ITEM, FUNC_LOAD, 6'd0,  8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h00, 1'b0, 1'b1, 1'b1, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h00, 1'b1, 1'b1, 1'b1, 32'd2},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h00, 1'b0, 1'b1, 1'b1, 32'd0},
		'{ROW_ITEM, FUNC_LOAD, 6'd63, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_LOAD, 6'd0,  8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'hFF, 1'b0, 1'b1, 1'b1, 32'd1},
		'{ROW_CFG,  FUNC_LOAD, 6'd0,  8'd0,  1'b0, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'hFF, 1'b1, 1'b1, 1'b1, 32'd2},
		'{ROW_CFG,  FUNC_LOAD, 6'd0,  8'd3,  1'b0, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_LOAD, 6'd0,  8'h41, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_LOAD, 6'd1,  8'h42, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_LOAD, 6'd2,  8'h41, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h41, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h41, 1'b0, 1'b1, 1'b1, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h41, 1'b0, 1'b1, 1'b1, 32'd2},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h42, 1'b1, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h41, 1'b0, 1'b1, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
		'{ROW_ITEM, FUNC_TEXT, 6'd0,  8'h41, 1'b0, 1'b1, 1'b1, 32'd0}
	};

	int phase_len [PHASES] = '{1, 64, 2, 127, 0, 3, 5, 4, 1, 2, 64, 7, 3, 6, 2, 1};

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic               func;
	logic [PIDX_W-1:0]  pattern_index;
	logic [BYTE_W-1:0]  data_byte;
	logic               last_byte;
	logic               result_valid;
	logic               result_stall;
	logic [MATCH_W-1:0] match_offset;
	logic               offset_saturated;
	logic               cfg_write_en;
	logic [LEN_W-1:0]   cfg_write_data;

	logic [BYTE_W-1:0]      pat_bytes [MAX_PATTERN];
	logic [BYTE_W-1:0]      text_window [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] next_offset;
	logic                   offset_pinned;
	logic [LEN_W-1:0]       cfg_len;

	match_t pending_matches [$];
	int     errors;
	int     cycles;
	int     send_idle_pct;
	int     stall_pct;
	bit     hold_req;
	int     hold_left;

	exact_byte_pattern_matcher u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.func             (func),
		.pattern_index    (pattern_index),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.match_offset     (match_offset),
		.offset_saturated (offset_saturated),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int live_length();
		if (cfg_len == 0)
			return 1;
		if (cfg_len > MAX_PATTERN)
			return MAX_PATTERN;
		return int'(cfg_len);
	endfunction

	function automatic bit match_text_byte(input logic [BYTE_W-1:0] b, input logic lst,
			output match_t m);
		int                     len;
		logic [OFFSET_BITS-1:0] pos;
		bit                     hit;
		for (int k = MAX_PATTERN - 1; k > 0; k--)
			text_window[k] = text_window[k-1];
		text_window[0] = b;
		len = live_length();
		pos = next_offset;
		if (pos == '1)
			offset_pinned = 1'b1;
		else
			next_offset = pos + 1'b1;
		hit = (pos >= OFFSET_BITS'(len - 1));
		for (int k = 0; k < len; k++)
			if (text_window[k] != pat_bytes[len-1-k])
				hit = 1'b0;
		m.offset    = MATCH_W'(pos - OFFSET_BITS'(len - 1));
		m.saturated = offset_pinned;
		if (lst) begin
			next_offset   = '0;
			offset_pinned = 1'b0;
		end
		return hit;
	endfunction

	task automatic send_item(input logic f, input logic [PIDX_W-1:0] idx,
			input logic [BYTE_W-1:0] d, input logic lst, input bit typed,
			input bit typed_hit, input logic [MATCH_W-1:0] typed_off);
		match_t m;
		bit     hit;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		func          <= f;
		pattern_index <= idx;
		data_byte     <= d;
		last_byte     <= lst;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (f == FUNC_LOAD) begin
			pat_bytes[idx] = d;
		end else begin
			hit = match_text_byte(d, lst, m);
			if (typed) begin
				hit         = typed_hit;
				m.offset    = typed_off;
				m.saturated = 1'b0;
			end
			if (hit)
				pending_matches = {pending_matches, m};
		end
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cfg_len = v;
	endtask

	task automatic run_phase(input int ph);
		int                len;
		int                sent;
		int                pick;
		logic [BYTE_W-1:0] sym_a;
		logic [BYTE_W-1:0] sym_b;
		logic [BYTE_W-1:0] b;
		case (ph % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 71;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 71;
			end
			default: begin
				send_idle_pct = 15;
				stall_pct     = 15;
			end
		endcase
		write_length(LEN_W'(phase_len[ph]));
		len   = live_length();
		sym_a = BYTE_W'($urandom_range(255));
		sym_b = BYTE_W'($urandom_range(255));
		for (int k = 0; k < len; k++)
			send_item(FUNC_LOAD, PIDX_W'(k), ($urandom_range(2) == 0) ? sym_b : sym_a,
				1'($urandom_range(1)), 1'b0, 1'b0, '0);
		if (ph % 8 == 0)
			hold_req = 1'b1;
		sent = 0;
		while (sent < PHASE_SIZE) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				send_item(FUNC_LOAD, PIDX_W'($urandom_range(MAX_PATTERN - 1)),
					BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0, '0);
				sent++;
			end else if (pick < 40) begin
				for (int k = 0; k < len; k++)
					send_item(FUNC_TEXT, PIDX_W'($urandom_range(MAX_PATTERN - 1)), pat_bytes[k],
						(k == len - 1) && ($urandom_range(3) == 0), 1'b0, 1'b0, '0);
				sent += len;
			end else begin
				if ($urandom_range(9) == 0)
					b = BYTE_W'($urandom_range(255));
				else
					b = $urandom_range(1) ? sym_a : sym_b;
				send_item(FUNC_TEXT, PIDX_W'($urandom_range(MAX_PATTERN - 1)), b,
					$urandom_range(29) == 0, 1'b0, 1'b0, '0);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		match_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected match, expected none, got offset %0d sat %0b",
					$time, match_offset, offset_saturated);
			end else begin
				want = pending_matches.pop_front();
				if (match_offset !== want.offset) begin
					errors++;
					$display("%0t: match_offset expected %0d, got %0d",
						$time, want.offset, match_offset);
				end
				if (offset_saturated !== want.saturated) begin
					errors++;
					$display("%0t: offset_saturated expected %0b, got %0b",
						$time, want.saturated, offset_saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb_exact_byte_pattern_matcher: errors");
			$finish;
		end
	end

	initial begin
		int guard;
		arst_n         <= 1'b0;
		item_valid     <= 1'b0;
		func           <= FUNC_LOAD;
		pattern_index  <= '0;
		data_byte      <= '0;
		last_byte      <= 1'b0;
		result_stall   <= 1'b0;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pat_bytes[k]   = '0;
			text_window[k] = '0;
		end
		next_offset   = '0;
		offset_pinned = 1'b0;
		cfg_len       = LEN_W'(1);
		errors        = 0;
		cycles        = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		hold_left     = 0;
		guard         = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			if (directed[r].kind == ROW_CFG)
				write_length(directed[r].data[LEN_W-1:0]);
			else
				send_item(directed[r].func, directed[r].index, directed[r].data,
					directed[r].last, directed[r].typed, directed[r].hit, directed[r].offset);
		end

		for (int ph = 0; ph < PHASES; ph++)
			run_phase(ph);

		item_valid <= 1'b0;
		while (pending_matches.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_matches.size() != 0) begin
			errors++;
			$display("%0t: %0d expected matches never arrived, next offset %0d",
				$time, pending_matches.size(), pending_matches[0].offset);
		end
		if (errors == 0)
			$display("tb_exact_byte_pattern_matcher: clean");
		else
			$display("tb_exact_byte_pattern_matcher: errors");
		$finish;
	end

endmodule
